### rtl/core/bld_pkg.sv
`timescale 1ns / 1ps
package bld_pkg;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);
  localparam int unsigned CfgW = 11;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;
  localparam logic OpPixel = 1'b0;
  localparam logic OpTable = 1'b1;
  localparam logic [1:0] SelRed = 2'd0;
  localparam logic [1:0] SelGreen = 2'd1;
  localparam logic [1:0] SelBlue = 2'd2;
  localparam logic [1:0] SelNone = 2'd3;
  localparam int unsigned InW = 32;
  localparam int unsigned OutW = 48;

  // One emitted pixel: window columns and the roles of the two line stores.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            up_is_prev; // upper window row comes from the previous line
    logic            cur_b;      // the line of the pixel word is store B
  } emit_t;
endpackage

### rtl/core/bld_ram.sv
`timescale 1ns / 1ps
module bld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### rtl/core/bld_seq.sv
`timescale 1ns / 1ps
// Walks the frame position and schedules pixels for emission, one per cycle while emit_ready is high.
module bld_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         is_pixel,
  input  logic [bld_pkg::CfgW-1:0]     width_cfg,
  input  logic [bld_pkg::CfgW-1:0]     height_cfg,
  input  logic                         emit_ready,
  output logic                         busy,
  output logic                         emit_valid,
  output bld_pkg::emit_t               emit_info,
  output logic [bld_pkg::ColW-1:0]     wr_col,
  output logic                         active
);
  logic [bld_pkg::RowW-1:0] row_r, row_nxt;
  logic [bld_pkg::ColW-1:0] col_r, col_nxt;
  logic                     act_r, act_nxt;
  // Pending emissions of the current word: up to four.
  logic [2:0]               left_r, left_nxt;
  logic [bld_pkg::RowW-1:0] erow_r, erow_nxt;
  logic [bld_pkg::ColW-1:0] ecol_r, ecol_nxt;
  logic                     quad_r, quad_nxt;
  logic                     eprev_r, eprev_nxt;
  logic                     eact_r, eact_nxt;
  logic [bld_pkg::CfgW-1:0] wlim, hlim;
  logic [bld_pkg::CfgW:0]   col_inc, row_inc;
  logic                     wrap;

  always_comb begin
    if (width_cfg < 11'd2) wlim = 11'd2;
    else if (width_cfg > bld_pkg::CfgW'(bld_pkg::MaxWidth))
      wlim = bld_pkg::CfgW'(bld_pkg::MaxWidth);
    else wlim = width_cfg;
    if (height_cfg < 11'd2) hlim = 11'd2;
    else if (height_cfg > bld_pkg::CfgW'(bld_pkg::MaxHeight))
      hlim = bld_pkg::CfgW'(bld_pkg::MaxHeight);
    else hlim = height_cfg;
  end

  assign col_inc = {2'b0, col_r} + 12'd1;
  assign row_inc = {2'b0, row_r} + 12'd1;
  assign wrap = col_inc >= {1'b0, wlim};
  assign busy = left_r != 3'd0;
  assign emit_valid = busy;
  assign wr_col = col_r;
  assign active = act_r;

  always_comb begin
    emit_info.row = erow_r;
    emit_info.col = ecol_r;
    emit_info.last = left_r == 3'd1;
    emit_info.up_is_prev = eprev_r;
    emit_info.cur_b = eact_r;
    if (quad_r) begin
      // Row 1, column 1: (0,0) (0,1) (1,0) (1,1).
      emit_info.row = {{(bld_pkg::RowW-1){1'b0}}, left_r <= 3'd2};
      emit_info.col = {{(bld_pkg::ColW-1){1'b0}}, left_r[0] == 1'b1};
      emit_info.up_is_prev = left_r <= 3'd2;
    end
  end

  always_comb begin
    row_nxt = row_r; col_nxt = col_r; act_nxt = act_r;
    left_nxt = left_r; erow_nxt = erow_r; ecol_nxt = ecol_r;
    quad_nxt = quad_r; eprev_nxt = eprev_r; eact_nxt = eact_r;
    if (busy && emit_ready) begin
      left_nxt = left_r - 3'd1;
      if (!quad_r) begin
        if (erow_r == '0) begin
          erow_nxt = {{(bld_pkg::RowW-1){1'b0}}, 1'b1};
          eprev_nxt = 1'b1;
        end else begin
          ecol_nxt = ecol_r + 1'b1;
        end
      end
    end
    if (in_fire && is_pixel) begin
      quad_nxt = 1'b0; eprev_nxt = 1'b1; erow_nxt = row_r; ecol_nxt = col_r;
      // The line roles are fixed by the word, before a row wrap swaps them.
      eact_nxt = act_r;
      if (row_r == {{(bld_pkg::RowW-1){1'b0}}, 1'b1}) begin
        if (col_r == {{(bld_pkg::ColW-1){1'b0}}, 1'b1}) begin
          left_nxt = 3'd4; quad_nxt = 1'b1;
        end else if (col_r >= bld_pkg::ColW'(2)) begin
          left_nxt = 3'd2; erow_nxt = '0; eprev_nxt = 1'b0;
        end
      end else if (row_r >= bld_pkg::RowW'(2)) begin
        if (col_r == {{(bld_pkg::ColW-1){1'b0}}, 1'b1}) begin
          left_nxt = 3'd2; ecol_nxt = '0;
        end else if (col_r >= bld_pkg::ColW'(2)) begin
          left_nxt = 3'd1;
        end
      end
      col_nxt = col_inc[bld_pkg::ColW-1:0];
      if (wrap) begin
        col_nxt = '0;
        act_nxt = ~act_r;
        row_nxt = (row_inc >= {1'b0, hlim}) ? '0 : row_inc[bld_pkg::RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; act_r <= 1'b0; left_r <= '0; quad_r <= 1'b0;
    end else begin
      row_r <= row_nxt; col_r <= col_nxt; act_r <= act_nxt;
      left_r <= left_nxt; quad_r <= quad_nxt;
    end
    erow_r <= erow_nxt; ecol_r <= ecol_nxt; eprev_r <= eprev_nxt; eact_r <= eact_nxt;
  end

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n) left_r <= 3'd4)
    else $error("emission count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_pixel) |-> (!busy || (left_r == 3'd1 && emit_ready)))
    else $error("pixel accepted while emissions pending");
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < bld_pkg::MaxWidth)
    else $error("column out of range");
endmodule

### rtl/core/bld_core.sv
`timescale 1ns / 1ps
// Reads the window from the line stores, maps it through the tables, registers it.
module bld_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic [bld_pkg::InW-1:0]  in_word,
  input  logic [bld_pkg::ColW-1:0] wr_col,
  input  logic                     active,
  input  logic                     emit_valid,
  input  bld_pkg::emit_t           emit_info,
  output logic                     emit_ready,
  output logic                     tbl_ready,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [bld_pkg::OutW-1:0] out_tdata,
  output logic                     out_tlast
);
  logic                     op;
  logic [7:0]               pix, tidx, tval;
  logic [1:0]               tsel;
  logic                     pix_we;
  logic                     we_a, we_b;
  logic [bld_pkg::ColW-1:0] xp, x;
  logic [bld_pkg::ColW-1:0] ra0, ra1;
  logic [7:0]               a0, a1, b0, b1;
  // Stage 1: store reads in flight. Stage 2: table reads in flight.
  logic                     s1_v_r;
  bld_pkg::emit_t           s1_r;
  logic                     s2_v_r;
  bld_pkg::emit_t           s2_r;
  logic [7:0]               up0, up1, cu0, cu1, ra, ga, gb, ba;
  logic [7:0]               rq, gqa, gqb, bq;
  logic [7:0]               rd, gd0, gd1, bd;
  logic [8:0]               gsum;
  logic                     o_v_r;
  logic [bld_pkg::OutW-1:0] o_d_r;
  logic                     o_l_r;
  logic                     adv;
  logic [1:0]               ph;

  assign op = in_word[0];
  assign pix = in_word[8:1];
  assign tsel = in_word[10:9];
  assign tidx = in_word[18:11];
  assign tval = in_word[26:19];
  assign pix_we = in_fire && op == bld_pkg::OpPixel;
  assign we_a = pix_we && !active;
  assign we_b = pix_we && active;

  // The output register frees when taken; stages advance together.
  assign adv = !o_v_r || out_tready;
  assign emit_ready = adv;
  // A table write waits until no issued pixel still has to read the tables.
  assign tbl_ready = !s1_v_r || adv;

  assign x = emit_info.col;
  assign xp = (x == '0) ? {{(bld_pkg::ColW-1){1'b0}}, 1'b1} : x - 1'b1;
  assign ra0 = xp;
  assign ra1 = x;

  // Store A/B each get two read ports by duplication; the write fans to both.
  bld_ram #(.Width(8), .Depth(bld_pkg::MaxWidth)) u_a0 (.clk, .we(we_a), .waddr(wr_col),
    .wdata(pix), .re(adv), .raddr(ra0), .rdata(a0));
  bld_ram #(.Width(8), .Depth(bld_pkg::MaxWidth)) u_a1 (.clk, .we(we_a), .waddr(wr_col),
    .wdata(pix), .re(adv), .raddr(ra1), .rdata(a1));
  bld_ram #(.Width(8), .Depth(bld_pkg::MaxWidth)) u_b0 (.clk, .we(we_b), .waddr(wr_col),
    .wdata(pix), .re(adv), .raddr(ra0), .rdata(b0));
  bld_ram #(.Width(8), .Depth(bld_pkg::MaxWidth)) u_b1 (.clk, .we(we_b), .waddr(wr_col),
    .wdata(pix), .re(adv), .raddr(ra1), .rdata(b1));

  // The current line is the one written; the upper window row is the previous
  // line unless this is a row-0 pixel.
  always_comb begin
    logic [7:0] p0, p1, c0, c1;
    p0 = s1_r.cur_b ? a0 : b0; p1 = s1_r.cur_b ? a1 : b1;
    c0 = s1_r.cur_b ? b0 : a0; c1 = s1_r.cur_b ? b1 : a1;
    up0 = s1_r.up_is_prev ? p0 : c0; up1 = s1_r.up_is_prev ? p1 : c1;
    cu0 = s1_r.up_is_prev ? c0 : p0; cu1 = s1_r.up_is_prev ? c1 : p1;
  end

  assign ph = {~s1_r.row[0], s1_r.col[0]};
  always_comb begin
    case (ph)
      2'd0: begin ga = up0; gb = cu1; ra = up1; ba = cu0; end
      2'd1: begin ra = up0; ga = up1; gb = cu0; ba = cu1; end
      2'd2: begin ba = up0; ga = up1; gb = cu0; ra = cu1; end
      default: begin ga = up0; gb = cu1; ba = up1; ra = cu0; end
    endcase
  end
  assign rq = ra; assign gqa = ga; assign gqb = gb; assign bq = ba;

  bld_ram #(.Width(8), .Depth(256)) u_r (.clk, .we(in_fire && op == bld_pkg::OpTable &&
    tsel == bld_pkg::SelRed), .waddr(tidx), .wdata(tval), .re(adv), .raddr(rq), .rdata(rd));
  bld_ram #(.Width(8), .Depth(256)) u_g0 (.clk, .we(in_fire && op == bld_pkg::OpTable &&
    tsel == bld_pkg::SelGreen), .waddr(tidx), .wdata(tval), .re(adv), .raddr(gqa),
    .rdata(gd0));
  bld_ram #(.Width(8), .Depth(256)) u_g1 (.clk, .we(in_fire && op == bld_pkg::OpTable &&
    tsel == bld_pkg::SelGreen), .waddr(tidx), .wdata(tval), .re(adv), .raddr(gqb),
    .rdata(gd1));
  bld_ram #(.Width(8), .Depth(256)) u_bl (.clk, .we(in_fire && op == bld_pkg::OpTable &&
    tsel == bld_pkg::SelBlue), .waddr(tidx), .wdata(tval), .re(adv), .raddr(bq), .rdata(bd));

  assign gsum = {1'b0, gd0} + {1'b0, gd1};

  // RAM reads are enabled with adv only, so read data stays with its stage
  // while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; o_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= emit_valid; s2_v_r <= s1_v_r; o_v_r <= s2_v_r;
    end
    if (adv) begin
      s1_r <= emit_info;
      s2_r <= s1_r;
      o_d_r <= {4'd0, s2_r.col, s2_r.row, bd, gsum[8:1], rd};
      o_l_r <= s2_r.last;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata = o_d_r;
  assign out_tlast = o_l_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output word dropped");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !emit_ready)
    else $error("pipeline moved under stall");
  a_tbl_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == bld_pkg::OpTable) |-> (!emit_valid && (!s1_v_r || adv)))
    else $error("table written before pending reads");
endmodule

### rtl/core/bayer_lut_demosaic_unit.sv
`timescale 1ns / 1ps
// Bayer demosaic with per-color tables. Input words carry either a raw byte
// or a table write; each raw byte yields zero to four RGB words with their
// coordinates (row 0 appears while row 1 arrives). Emission runs at one word
// per cycle, unless the output stalls, through a three-stage pipeline (line
// store read, table read, output register); the next pixel word is taken as
// the last word of the previous one issues. A table word waits until every
// earlier pixel has read the tables. Output stalls hold the whole pipeline;
// the input waits only while words are pending or a pixel must read tables.
module bayer_lut_demosaic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode, raw_pixel, table_select, table_index, table_value, zero pad
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red, green, blue, pixel_row, pixel_column, zero pad
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  logic [10:0]                w_r, h_r;
  logic                       fire, busy, ev, er, act, tok;
  bld_pkg::emit_t             ei;
  logic [bld_pkg::ColW-1:0]   wc;

  // Take a pixel word once the pending emissions finish this cycle; a table
  // word only once nothing issued still has to read the tables.
  assign in_tready = (in_tdata[0] == bld_pkg::OpTable) ? (!busy && tok)
                                                       : (!busy || (ei.last && er));
  assign fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 11'd640; h_r <= 11'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bld_pkg::RegFrameWidth: w_r <= cfg_data;
        bld_pkg::RegFrameHeight: h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bld_seq u_seq (.clk, .rst_n, .in_fire(fire), .is_pixel(in_tdata[0] == bld_pkg::OpPixel),
    .width_cfg(w_r), .height_cfg(h_r), .emit_ready(er), .busy, .emit_valid(ev),
    .emit_info(ei), .wr_col(wc), .active(act));

  bld_core u_core (.clk, .rst_n, .in_fire(fire), .in_word(in_tdata), .wr_col(wc),
    .active(act), .emit_valid(ev), .emit_info(ei), .emit_ready(er), .tbl_ready(tok),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);
endmodule
